/* hdl/lpid_pkg.sv */
// lpid_pkg: shared types and constants for the linked pool insert/delete unit
// item structs, command and status codes, pool geometry and marker values
// no dependencies
package lpid_pkg;

  localparam int POOL_NODES = 16;
  localparam int IX_W       = 4;   // bits of a node index
  localparam int LINK_W     = 5;   // bits of a link, one more for nil

  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);
  localparam logic [31:0] MARK_ID    = 32'hFFFF_FFFF;
  localparam logic [31:0] MARK_GRADE = 32'hBF80_0000;  // -1.0

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_SUCC = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]      command;
    logic            at_front;
    logic [IX_W-1:0] pred_index;
    logic [IX_W-1:0] read_index;
    logic [31:0]     student_id;
    logic [31:0]     grade_bits;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LINK_W-1:0] node_used;
    logic [LINK_W-1:0] head_now;
    logic [LINK_W-1:0] free_now;
    logic              list_empty;
    logic              list_full;
    logic [31:0]       read_id;
    logic [31:0]       read_grade;
    logic [LINK_W-1:0] read_next;
  } rsp_item_t;

  // request from the link logic to the data store
  typedef struct packed {
    logic            wr_en;
    logic [IX_W-1:0] wr_ix;
    logic [31:0]     wr_id;
    logic [31:0]     wr_grade;
    logic            rd_en;
    logic [IX_W-1:0] rd_ix;
  } data_req_t;

  // per-item result of the link logic
  typedef struct packed {
    logic [1:0]        status;
    logic [LINK_W-1:0] used;
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] free;
    logic [LINK_W-1:0] read_next;
    logic              is_read;
  } link_res_t;

endpackage

/* hdl/lpid_links.sv */
// lpid_links: link store, list head and free-list head with the update logic
// depends on lpid_pkg
module lpid_links (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  lpid_pkg::cmd_item_t cmd,
  output lpid_pkg::data_req_t req,
  output lpid_pkg::link_res_t res
);

  localparam int N  = lpid_pkg::POOL_NODES;
  localparam int LW = lpid_pkg::LINK_W;
  localparam int IW = lpid_pkg::IX_W;

  logic [LW-1:0] links      [N];
  logic [LW-1:0] links_next [N];
  logic [LW-1:0] head, head_next;
  logic [LW-1:0] free, free_next;

  logic [IW-1:0] nf, nh, ns;
  logic [LW-1:0] succ;

  assign nf   = free[IW-1:0];
  assign nh   = head[IW-1:0];
  assign succ = links[cmd.pred_index];
  assign ns   = succ[IW-1:0];

  always_comb begin
    links_next   = links;
    head_next    = head;
    free_next    = free;
    res.status   = lpid_pkg::ST_OK;
    res.used     = lpid_pkg::NIL;
    res.read_next = lpid_pkg::NIL;
    res.is_read  = 1'b0;
    req.wr_en    = 1'b0;
    req.wr_ix    = nf;
    req.wr_id    = cmd.student_id;
    req.wr_grade = cmd.grade_bits;
    req.rd_en    = 1'b0;
    req.rd_ix    = cmd.read_index;
    case (cmd.command)
      lpid_pkg::CMD_INSERT: begin
        if (free == lpid_pkg::NIL) begin
          res.status = lpid_pkg::ST_FULL;
        end else begin
          free_next = links[nf];
          req.wr_en = go;
          res.used  = free;
          if (cmd.at_front) begin
            links_next[nf] = head;
            head_next      = free;
          end else begin
            // predecessor write last: wins when it is the new node itself
            links_next[nf]             = succ;
            links_next[cmd.pred_index] = free;
          end
        end
      end
      lpid_pkg::CMD_DELETE: begin
        req.wr_id    = lpid_pkg::MARK_ID;
        req.wr_grade = lpid_pkg::MARK_GRADE;
        if (head == lpid_pkg::NIL) begin
          res.status = lpid_pkg::ST_EMPTY;
        end else if (cmd.at_front) begin
          head_next      = links[nh];
          links_next[nh] = free;
          free_next      = head;
          req.wr_en      = go;
          req.wr_ix      = nh;
          res.used       = head;
        end else if (succ == lpid_pkg::NIL) begin
          res.status = lpid_pkg::ST_NO_SUCC;
        end else begin
          links_next[cmd.pred_index] = links[ns];
          links_next[ns]             = free;
          free_next                  = succ;
          req.wr_en                  = go;
          req.wr_ix                  = ns;
          res.used                   = succ;
        end
      end
      lpid_pkg::CMD_READ: begin
        req.rd_en     = go;
        res.is_read   = 1'b1;
        res.used      = LW'(cmd.read_index);
        res.read_next = links[cmd.read_index];
      end
      default: begin
      end
    endcase
    res.head = head_next;
    res.free = free_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        links[i] <= LW'(i + 1);
      end
      head <= lpid_pkg::NIL;
      free <= '0;
    end else if (go) begin
      links <= links_next;
      head  <= head_next;
      free  <= free_next;
    end
  end

endmodule

/* hdl/lpid_data.sv */
// lpid_data: id and grade memories with per-entry valid bits
// depends on lpid_pkg; never-written entries read as the -1 markers
module lpid_data (
  input  logic                clk,
  input  logic                rst,
  input  lpid_pkg::data_req_t req,
  output logic [31:0]         rd_id,
  output logic [31:0]         rd_grade
);

  localparam int N = lpid_pkg::POOL_NODES;

  logic [31:0]  id_mem    [N];
  logic [31:0]  grade_mem [N];
  logic [N-1:0] vld;
  logic [31:0]  id_q, grade_q;
  logic         hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      id_mem[req.wr_ix]    <= req.wr_id;
      grade_mem[req.wr_ix] <= req.wr_grade;
    end
    if (req.rd_en) begin
      id_q    <= id_mem[req.rd_ix];
      grade_q <= grade_mem[req.rd_ix];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      hit <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_ix] <= 1'b1;
      end
      if (req.rd_en) begin
        hit <= vld[req.rd_ix];
      end
    end
  end

  assign rd_id    = hit ? id_q    : lpid_pkg::MARK_ID;
  assign rd_grade = hit ? grade_q : lpid_pkg::MARK_GRADE;

endmodule

/* hdl/linked_pool_insert_delete_unit.sv */
// linked pool insert/delete unit: 16-node pool shared by one list and a free list
// an accepted item's result is registered and shown on rsp in the cycle after it is accepted
// throughput: 1 item per cycle while rsp is not stalled; each item reads and rewrites at most two links
//   and the two list heads in flip-flops, the id/grade memory has one port each way
// reset (rst, synchronous): node i links to i+1, data reads as -1 markers,
//   list empty, free list starts at node 0; ready in the first cycle after reset
module linked_pool_insert_delete_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  lpid_pkg::cmd_item_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lpid_pkg::rsp_item_t rsp
);

  // handshake: hold off only while the result register is full and not taken
  logic go;
  assign cmd_stall = rsp_valid & rsp_stall;
  assign go        = cmd_valid & ~cmd_stall;

  lpid_pkg::data_req_t req;
  lpid_pkg::link_res_t res;
  lpid_pkg::link_res_t meta;   // registered link result for the waiting item
  logic [31:0]         rd_id, rd_grade;

  // list and free-list links, all pointer updates happen here
  lpid_links u_links (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .cmd (cmd),
    .req (req),
    .res (res)
  );

  // node payload; read data is registered in step with meta
  lpid_data u_data (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_id    (rd_id),
    .rd_grade (rd_grade)
  );

  // result register: payload needs no reset, valid does
  always_ff @(posedge clk) begin
    if (go) begin
      meta <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // assemble the result item; read id and grade are zero and read_next is nil for anything but a read
  always_comb begin
    rsp.status     = meta.status;
    rsp.node_used  = meta.used;
    rsp.head_now   = meta.head;
    rsp.free_now   = meta.free;
    rsp.list_empty = (meta.head == lpid_pkg::NIL);
    rsp.list_full  = (meta.free == lpid_pkg::NIL);
    rsp.read_id    = meta.is_read ? rd_id    : '0;
    rsp.read_grade = meta.is_read ? rd_grade : '0;
    rsp.read_next  = meta.read_next;
  end

endmodule

/* hdl/lpid_checker.sv */
// lpid_checker: port-level checks for the linked pool unit, bound to the top level
// depends on lpid_pkg
module lpid_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input lpid_pkg::cmd_item_t cmd,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input lpid_pkg::rsp_item_t rsp
);

  // every accepted item shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> rsp_valid)
    else $error("accepted item produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_empty == (rsp.head_now == lpid_pkg::NIL)))
    else $error("list_empty disagrees with head_now");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_full == (rsp.free_now == lpid_pkg::NIL)))
    else $error("list_full disagrees with free_now");

  // a refused command touches no node
  a_err_no_node: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != lpid_pkg::ST_OK |-> rsp.node_used == lpid_pkg::NIL)
    else $error("failed command reports a node");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind linked_pool_insert_delete_unit lpid_checker u_lpid_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
